/* sv/msvs_pkg.sv */
// Shared types, codes and defaults of the multi-slot vector store.
`default_nettype none

package msvs_pkg;

   localparam int SLOTS_DEF   = 8;
   localparam int CAP_MAX_DEF = 16;

   localparam int FUNC_W = 3;
   localparam int SLOT_W = 4;
   localparam int DATA_W = 32;
   localparam int AMT_W  = 8;
   localparam int STAT_W = 4;
   localparam int CNT_W  = 5;

   typedef enum logic [FUNC_W-1:0] {
      FN_CREATE      = 3'd0,
      FN_APPEND      = 3'd1,
      FN_REMOVE_LAST = 3'd2,
      FN_REMOVE_VAL  = 3'd3,
      FN_RESIZE      = 3'd4,
      FN_COUNT       = 3'd5,
      FN_READ        = 3'd6,
      FN_READ_SORTED = 3'd7
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 4'd0,
      ST_BAD_SLOT     = 4'd1,
      ST_EXISTS       = 4'd2,
      ST_BAD_SIZE     = 4'd3,
      ST_NO_MEMORY    = 4'd4,
      ST_FULL         = 4'd5,
      ST_NO_LIST      = 4'd6,
      ST_EMPTY        = 4'd7,
      ST_NOT_FOUND    = 4'd8,
      ST_BAD_NEW_SIZE = 4'd9
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       single;
      logic       rd_en;
      logic       clr_i;
      logic       inc_i;
      logic       clr_k;
      logic       inc_k;
      logic       shift_wr;
      logic       emit;
      logic       emit_elem;
      logic       emit_sorted;
      logic       dec_count;
      logic       sort_clr;
      logic       sort_cmp;
      logic       sort_take;
      status_type emit_st;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      func_type func;
      logic     bad_slot;
      logic     present;
      logic     n_zero;
      logic     match;
      logic     i_end;
      logic     k_end;
      logic     out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

/* sv/msvs_if.sv */
// Request and response channel interfaces of the multi-slot vector store.
`default_nettype none

interface msvs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [msvs_pkg::FUNC_W-1:0]          func;
   logic [msvs_pkg::SLOT_W-1:0]          slot;
   logic signed [msvs_pkg::DATA_W-1:0]   data_value;
   logic signed [msvs_pkg::AMT_W-1:0]    amount;

   modport source (output valid, func, slot, data_value, amount, input ready);
   modport sink   (input valid, func, slot, data_value, amount, output ready);
endinterface

interface msvs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [msvs_pkg::STAT_W-1:0]          status;
   logic [msvs_pkg::CNT_W-1:0]           count;
   logic signed [msvs_pkg::DATA_W-1:0]   read_value;
   logic                                 value_valid;
   logic                                 last;

   modport source (output valid, status, count, read_value, value_valid, last,
                   input ready);
   modport sink   (input valid, status, count, read_value, value_valid, last,
                   output ready);
endinterface

`default_nettype wire

/* sv/multi_slot_vector_store.sv */
// Top level of the multi-slot vector store.
`default_nettype none

// SLOTS numbered bounded lists of signed 32-bit words, kept in one element
// RAM of SLOTS*CAP_MAX entries (CAP_MAX entries per list) with a registered
// read port; list presence, capacity and count live in flip-flops cleared by
// reset, so no clearing pass is needed. One request word runs at a time and
// gives one response word, or one per element for a read; no request word is
// taken while reset is high. Create, append, remove last, resize, count, a
// read of an empty list and every error load their response word from the
// decode state once the output register is free. Remove by value reads the
// entries in order until one matches and then moves each later entry down
// one place, so it visits every entry of the list, hit or miss, before its
// response word is loaded. A stored-order read loads one word per entry,
// each from its own address and data states. A sorted read runs a full scan
// of the list for every word it gives, since the single RAM read port is
// what paces every walk. The next request word is taken the cycle after the
// final response word is loaded, so the longest item is a sorted read of a
// full list. The response word sits in an output register; a stalled response
// only holds the walk at the point where the next word would be loaded.
module multi_slot_vector_store #(
   parameter int SLOTS   = msvs_pkg::SLOTS_DEF,
   parameter int CAP_MAX = msvs_pkg::CAP_MAX_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   msvs_req_if.sink  req_chan,
   msvs_rsp_if.source rsp_chan
);

   msvs_pkg::cmd_type     cmd;
   msvs_pkg::dp_stat_type stat;
   logic                  req_ready;
   logic                  accept;

   // take a request word only while the controller is idle
   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   msvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // hold tables, RAM and the response register in the datapath
   msvs_dp #(
      .SLOTS   (SLOTS),
      .CAP_MAX (CAP_MAX)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_func         (req_chan.func),
      .in_slot         (req_chan.slot),
      .in_data_value   (req_chan.data_value),
      .in_amount       (req_chan.amount),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_status      (rsp_chan.status),
      .out_count       (rsp_chan.count),
      .out_read_value  (rsp_chan.read_value),
      .out_value_valid (rsp_chan.value_valid),
      .out_last        (rsp_chan.last)
   );

`ifndef ASSERT_OFF
   // a request word is never taken back to back
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request taken while an operation is running");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (int'(rsp_chan.count) <= CAP_MAX))
      else $error("response count above list capacity");

   a_element_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.value_valid) |->
         (rsp_chan.status == msvs_pkg::ST_OK))
      else $error("element word with error status");

   a_bad_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == msvs_pkg::ST_BAD_SLOT) |->
         (rsp_chan.count == '0 && rsp_chan.last))
      else $error("bad slot response malformed");
`endif

endmodule

`default_nettype wire

/* sv/msvs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* sv/msvs_ctrl.sv */
// Controller state machine of the multi-slot vector store.
`default_nettype none

module msvs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire msvs_pkg::dp_stat_type stat,
   output msvs_pkg::cmd_type          cmd,
   output logic                       req_ready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RV_ADDR,
      S_RV_DATA,
      S_SH_ADDR,
      S_SH_DATA,
      S_RV_DONE,
      S_RV_MISS,
      S_RD_ADDR,
      S_RD_DATA,
      S_SO_ADDR,
      S_SO_DATA,
      S_SO_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      multi;

   // walks only when the list exists and holds entries
   assign multi = !stat.bad_slot && stat.present && !stat.n_zero &&
                  (stat.func == msvs_pkg::FN_REMOVE_VAL ||
                   stat.func == msvs_pkg::FN_READ ||
                   stat.func == msvs_pkg::FN_READ_SORTED);

   // hold off requests while reset is applied
   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      cmd      = '0;
      cmd.emit_st = msvs_pkg::ST_OK;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!multi) begin
               if (stat.out_free) begin
                  cmd.single = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.clr_i    = 1'b1;
               cmd.clr_k    = 1'b1;
               cmd.sort_clr = 1'b1;
               case (stat.func)
                  msvs_pkg::FN_REMOVE_VAL: state_in = S_RV_ADDR;
                  msvs_pkg::FN_READ:       state_in = S_RD_ADDR;
                  default:                 state_in = S_SO_ADDR;
               endcase
            end
         end
         S_RV_ADDR: begin
            cmd.rd_en = 1'b1;
            state_in  = S_RV_DATA;
         end
         S_RV_DATA: begin
            if (stat.match) begin
               if (stat.i_end) begin
                  state_in = S_RV_DONE;
               end else begin
                  cmd.inc_i = 1'b1;
                  state_in  = S_SH_ADDR;
               end
            end else if (stat.i_end) begin
               state_in = S_RV_MISS;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = S_RV_ADDR;
            end
         end
         S_SH_ADDR: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SH_DATA;
         end
         S_SH_DATA: begin
            cmd.shift_wr = 1'b1;
            if (stat.i_end) begin
               state_in = S_RV_DONE;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = S_SH_ADDR;
            end
         end
         S_RV_DONE: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.dec_count = 1'b1;
               cmd.emit_st   = msvs_pkg::ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_RV_MISS: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.emit_st = msvs_pkg::ST_NOT_FOUND;
               state_in    = S_IDLE;
            end
         end
         S_RD_ADDR: begin
            cmd.rd_en = 1'b1;
            state_in  = S_RD_DATA;
         end
         S_RD_DATA: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_elem = 1'b1;
               if (stat.i_end) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.inc_i = 1'b1;
                  state_in  = S_RD_ADDR;
               end
            end
         end
         S_SO_ADDR: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SO_DATA;
         end
         S_SO_DATA: begin
            cmd.sort_cmp = 1'b1;
            if (stat.i_end) begin
               state_in = S_SO_EMIT;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = S_SO_ADDR;
            end
         end
         S_SO_EMIT: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_sorted = 1'b1;
               cmd.sort_take   = 1'b1;
               cmd.clr_i       = 1'b1;
               cmd.inc_k       = 1'b1;
               state_in        = stat.k_end ? S_IDLE : S_SO_ADDR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/msvs_dp.sv */
// Datapath of the multi-slot vector store: list tables, element RAM, output word.
`default_nettype none

module msvs_dp #(
   parameter int SLOTS   = msvs_pkg::SLOTS_DEF,
   parameter int CAP_MAX = msvs_pkg::CAP_MAX_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire msvs_pkg::cmd_type                   cmd,
   output msvs_pkg::dp_stat_type                    stat,
   input  wire logic [msvs_pkg::FUNC_W-1:0]         in_func,
   input  wire logic [msvs_pkg::SLOT_W-1:0]         in_slot,
   input  wire logic signed [msvs_pkg::DATA_W-1:0]  in_data_value,
   input  wire logic signed [msvs_pkg::AMT_W-1:0]   in_amount,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [msvs_pkg::STAT_W-1:0]              out_status,
   output logic [msvs_pkg::CNT_W-1:0]               out_count,
   output logic signed [msvs_pkg::DATA_W-1:0]       out_read_value,
   output logic                                     out_value_valid,
   output logic                                     out_last
);

   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(CAP_MAX + 1);
   localparam int DEPTH = SLOTS * CAP_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = msvs_pkg::DATA_W;

   msvs_pkg::func_type              func_ff;
   logic [msvs_pkg::SLOT_W-1:0]     slot_ff;
   logic [DW-1:0]                   val_ff;
   logic [msvs_pkg::AMT_W-1:0]      amt_ff;

   logic                            present_ff [SLOTS];
   logic [CW-1:0]                   cap_ff     [SLOTS];
   logic [CW-1:0]                   cnt_ff     [SLOTS];

   logic [CW-1:0]                   i_ff, k_ff;
   logic                            have_prev_ff, best_found_ff;
   logic [DW-1:0]                   prev_val_ff, best_val_ff;
   logic [CW-1:0]                   prev_idx_ff, best_idx_ff;

   logic                            out_valid_ff;
   logic [msvs_pkg::STAT_W-1:0]     out_status_ff;
   logic [CW-1:0]                   out_count_ff;
   logic [DW-1:0]                   out_value_ff;
   logic                            out_vv_ff;
   logic                            out_last_ff;

   logic                            bad;
   logic [SW-1:0]                   sidx;
   logic                            present;
   logic [CW-1:0]                   n, cap, n_dec;
   logic [AW-1:0]                   base;
   logic [DW-1:0]                   rdata;
   logic                            out_free;
   logic                            i_end, k_end;

   logic                            amt_lt1, amt_gt;
   logic signed [9:0]               newcap;
   logic                            nc_lt1, nc_gt;
   logic [CW-1:0]                   newcap_c, clamp;

   msvs_pkg::status_type            s_st;
   logic [CW-1:0]                   s_cnt;
   logic                            do_create, do_append, do_rmlast, do_resize;

   logic                            ram_we, ram_re;
   logic [AW-1:0]                   ram_waddr, ram_raddr;
   logic [DW-1:0]                   ram_wdata;

   logic                            qualify, better;
   logic                            load_out;
   logic [msvs_pkg::STAT_W-1:0]     o_st;
   logic [CW-1:0]                   o_cnt;
   logic [DW-1:0]                   o_val;
   logic                            o_vv, o_last;

   // slot decode and table lookup
   assign bad     = (slot_ff == '0) || ({1'b0, slot_ff} > 5'(SLOTS));
   assign sidx    = bad ? '0 : SW'(slot_ff - 4'd1);
   assign present = present_ff[sidx];
   assign n       = cnt_ff[sidx];
   assign cap     = cap_ff[sidx];
   assign n_dec   = n - CW'(1);
   assign base    = AW'(int'(sidx) * CAP_MAX);
   assign i_end   = (i_ff == n_dec);
   assign k_end   = (k_ff == n_dec);
   assign out_free = !out_valid_ff || out_ready;

   assign stat.func     = func_ff;
   assign stat.bad_slot = bad;
   assign stat.present  = present;
   assign stat.n_zero   = (n == '0);
   assign stat.match    = (rdata == val_ff);
   assign stat.i_end    = i_end;
   assign stat.k_end    = k_end;
   assign stat.out_free = out_free;

   // size checks for create and resize
   assign amt_lt1  = $signed(amt_ff) < 8'sd1;
   assign amt_gt   = $signed(amt_ff) > $signed(8'(CAP_MAX));
   assign newcap   = $signed({{(10-CW){1'b0}}, cap}) + $signed({{2{amt_ff[7]}}, amt_ff});
   assign nc_lt1   = newcap < 10'sd1;
   assign nc_gt    = newcap > $signed(10'(CAP_MAX));
   assign newcap_c = CW'(newcap);
   assign clamp    = (n > newcap_c) ? newcap_c : n;

   // one-word operations
   always_comb begin
      s_st      = msvs_pkg::ST_OK;
      s_cnt     = n;
      do_create = 1'b0;
      do_append = 1'b0;
      do_rmlast = 1'b0;
      do_resize = 1'b0;
      if (bad) begin
         s_st  = msvs_pkg::ST_BAD_SLOT;
         s_cnt = '0;
      end else if (func_ff == msvs_pkg::FN_CREATE) begin
         if (present) begin
            s_st = msvs_pkg::ST_EXISTS;
         end else if (amt_lt1) begin
            s_st = msvs_pkg::ST_BAD_SIZE;
         end else if (amt_gt) begin
            s_st = msvs_pkg::ST_NO_MEMORY;
         end else begin
            do_create = 1'b1;
            s_cnt     = '0;
         end
      end else if (!present) begin
         s_st = msvs_pkg::ST_NO_LIST;
      end else begin
         case (func_ff)
            msvs_pkg::FN_APPEND: begin
               if (n < cap) begin
                  do_append = 1'b1;
                  s_cnt     = n + CW'(1);
               end else begin
                  s_st = msvs_pkg::ST_FULL;
               end
            end
            msvs_pkg::FN_REMOVE_LAST: begin
               if (n == '0) begin
                  s_st = msvs_pkg::ST_EMPTY;
               end else begin
                  do_rmlast = 1'b1;
                  s_cnt     = n_dec;
               end
            end
            msvs_pkg::FN_REMOVE_VAL: s_st = msvs_pkg::ST_EMPTY;
            msvs_pkg::FN_RESIZE: begin
               if (nc_lt1) begin
                  s_st = msvs_pkg::ST_BAD_NEW_SIZE;
               end else if (nc_gt) begin
                  s_st = msvs_pkg::ST_NO_MEMORY;
               end else begin
                  do_resize = 1'b1;
                  s_cnt     = clamp;
               end
            end
            msvs_pkg::FN_COUNT: begin
               if (n == '0) begin
                  s_st = msvs_pkg::ST_EMPTY;
               end
            end
            default: s_st = msvs_pkg::ST_OK;
         endcase
      end
   end

   // element RAM ports
   assign ram_we    = (cmd.single && do_append) || cmd.shift_wr;
   assign ram_waddr = cmd.shift_wr ? (base + AW'(i_ff) - AW'(1)) : (base + AW'(n));
   assign ram_wdata = cmd.shift_wr ? rdata : val_ff;
   assign ram_re    = cmd.rd_en;
   assign ram_raddr = base + AW'(i_ff);

   msvs_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   // next smallest word above the last one taken; ties go by position
   assign qualify = !have_prev_ff || ($signed(rdata) > $signed(prev_val_ff)) ||
                    ((rdata == prev_val_ff) && (i_ff > prev_idx_ff));
   assign better  = !best_found_ff || ($signed(rdata) < $signed(best_val_ff));

   // output word selection
   assign load_out = cmd.single || cmd.emit;
   assign o_st     = cmd.single ? s_st : cmd.emit_st;
   assign o_cnt    = cmd.single ? s_cnt : (cmd.dec_count ? n_dec : n);
   assign o_vv     = !cmd.single && (cmd.emit_elem || cmd.emit_sorted);
   assign o_val    = cmd.single      ? '0 :
                     cmd.emit_elem   ? rdata :
                     cmd.emit_sorted ? best_val_ff : '0;
   assign o_last   = cmd.single      ? 1'b1 :
                     cmd.emit_elem   ? i_end :
                     cmd.emit_sorted ? k_end : 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= msvs_pkg::func_type'(in_func);
         slot_ff <= in_slot;
         val_ff  <= in_data_value;
         amt_ff  <= in_amount;
      end
      if (cmd.clr_i) begin
         i_ff <= '0;
      end else if (cmd.inc_i) begin
         i_ff <= i_ff + CW'(1);
      end
      if (cmd.clr_k) begin
         k_ff <= '0;
      end else if (cmd.inc_k) begin
         k_ff <= k_ff + CW'(1);
      end
      if (cmd.sort_cmp && qualify && better) begin
         best_val_ff <= rdata;
         best_idx_ff <= i_ff;
      end
      if (cmd.sort_take) begin
         prev_val_ff <= best_val_ff;
         prev_idx_ff <= best_idx_ff;
      end
      if (load_out) begin
         out_status_ff <= o_st;
         out_count_ff  <= o_cnt;
         out_value_ff  <= o_val;
         out_vv_ff     <= o_vv;
         out_last_ff   <= o_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            present_ff[s] <= 1'b0;
            cap_ff[s]     <= '0;
            cnt_ff[s]     <= '0;
         end
         have_prev_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.single && do_create) begin
            present_ff[sidx] <= 1'b1;
            cap_ff[sidx]     <= CW'(amt_ff);
            cnt_ff[sidx]     <= '0;
         end
         if (cmd.single && do_append) begin
            cnt_ff[sidx] <= n + CW'(1);
         end
         if (cmd.single && do_rmlast) begin
            cnt_ff[sidx] <= n_dec;
         end
         if (cmd.single && do_resize) begin
            cap_ff[sidx] <= newcap_c;
            cnt_ff[sidx] <= clamp;
         end
         if (cmd.emit && cmd.dec_count) begin
            cnt_ff[sidx] <= n_dec;
         end
         if (cmd.sort_clr) begin
            have_prev_ff  <= 1'b0;
            best_found_ff <= 1'b0;
         end else if (cmd.sort_take) begin
            have_prev_ff  <= 1'b1;
            best_found_ff <= 1'b0;
         end else if (cmd.sort_cmp && qualify && better) begin
            best_found_ff <= 1'b1;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_status      = out_status_ff;
   assign out_count       = msvs_pkg::CNT_W'(out_count_ff);
   assign out_read_value  = out_value_ff;
   assign out_value_valid = out_vv_ff;
   assign out_last        = out_last_ff;

endmodule

`default_nettype wire
